@@ sv/ipa_pkg.sv @@
// Shared types, codes and defaults for the IPv4 address pool allocator.
package ipa_pkg;

    // Default number of host offset bits (pool holds 2^HOST_BITS offsets)
    localparam int unsigned IPA_HOST_BITS = 8;

    // Prefix length after reset
    localparam logic [5:0] PREFIX_RESET = 6'd24;
    localparam logic [5:0] PREFIX_MAX   = 6'd32;

    // Function codes
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_REBUILD = 2'd2;
    localparam logic [1:0] FUNC_NOP     = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] REG_NET_BASE   = 8'd0;
    localparam logic [7:0] REG_PREFIX_LEN = 8'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr_in;
    } ipa_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr_out;
        logic        in_subnet;
        logic [7:0]  free_count;
    } ipa_resp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch request, read queue head and bitmap
        logic exec;    // apply the latched request
        logic sweep;   // write one sweep entry and advance
        logic emit;    // register the result
    } ipa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_rebuild;
        logic sweep_last;
    } ipa_stat_t;

endpackage

@@ sv/ipa_ctrl.sv @@
// Sequencing state machine of the IPv4 address pool allocator.
module ipa_ctrl
    import ipa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  ipa_stat_t stat,
    output ipa_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_SWEEP = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_rebuild)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ sv/ipa_datapath.sv @@
// Free list, allocation bitmap, subnet registers and result register.
module ipa_datapath
    import ipa_pkg::*;
#(
    parameter int unsigned HOST_BITS = IPA_HOST_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  ipa_req_t    req,
    input  ipa_cmd_t    cmd,
    output ipa_stat_t   stat,
    output ipa_resp_t   resp,
    output logic        done
);

    localparam int unsigned POOL  = 1 << HOST_BITS;
    localparam int unsigned CNT_W = HOST_BITS + 1;
    localparam logic [5:0]  P_MIN = 6'(32 - HOST_BITS);

    // Storage
    logic [HOST_BITS-1:0] free_queue_mem [POOL];
    logic                 taken_mem      [POOL];

    // Configuration registers
    logic [31:0] net_base_reg;
    logic [5:0]  prefix_reg;

    // Pool state
    logic [31:0]          base_reg,  base_next;
    logic [31:0]          mask_reg,  mask_next;
    logic [HOST_BITS-1:0] head_reg,  head_next;
    logic [HOST_BITS-1:0] tail_reg,  tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [HOST_BITS-1:0] idx_reg,   idx_next;
    logic [HOST_BITS-1:0] last_reg,  last_next;

    // Latched request and read data
    ipa_req_t             req_reg;
    logic [HOST_BITS-1:0] q_rdata_reg;
    logic                 taken_rdata_reg;

    // Result
    ipa_resp_t resp_reg;
    logic      done_reg;

    // Write port controls
    logic                 taken_we;
    logic [HOST_BITS-1:0] taken_wa;
    logic                 taken_wd;
    logic                 q_we;
    logic [HOST_BITS-1:0] q_wa;
    logic [HOST_BITS-1:0] q_wd;

    // Combinational helpers
    logic [HOST_BITS-1:0] load_off;
    logic [HOST_BITS-1:0] off_c;
    logic                 hit_c;
    logic [5:0]           p_c;
    logic [4:0]           hb_c;
    logic [31:0]          new_mask;
    logic [CNT_W-1:0]     size_c;
    logic [CNT_W-1:0]     rb_count;
    logic [1:0]           status_c;
    logic [31:0]          granted_c;
    logic                 in_subnet_c;
    logic [CNT_W+7:0]     cnt_ext;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_base_reg <= '0;
            prefix_reg   <= PREFIX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NET_BASE:   net_base_reg <= cfg_data;
                REG_PREFIX_LEN: prefix_reg   <= cfg_data[5:0];
                default:        ;
            endcase
        end
    end

    // Clamp prefix and derive the new subnet geometry
    always_comb
    begin
        if (prefix_reg > PREFIX_MAX)
        begin
            p_c = PREFIX_MAX;
        end
        else if (prefix_reg < P_MIN)
        begin
            p_c = P_MIN;
        end
        else
        begin
            p_c = prefix_reg;
        end
        hb_c     = 5'(PREFIX_MAX - p_c);
        new_mask = 32'hFFFF_FFFF << hb_c;
        size_c   = CNT_W'(1) << hb_c;
        rb_count = (size_c > CNT_W'(3)) ? (size_c - CNT_W'(3)) : '0;
    end

    // Host offsets of the incoming and the latched address
    assign load_off = req.addr_in[HOST_BITS-1:0] & ~mask_reg[HOST_BITS-1:0];
    assign off_c    = req_reg.addr_in[HOST_BITS-1:0] & ~mask_reg[HOST_BITS-1:0];
    assign hit_c    = (req_reg.addr_in & mask_reg) == base_reg;

    // Apply sweep or request
    always_comb
    begin
        base_next  = base_reg;
        mask_next  = mask_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        status_c   = STAT_DONE;
        granted_c  = '0;
        taken_we   = 1'b0;
        taken_wa   = idx_reg;
        taken_wd   = 1'b0;
        q_we       = 1'b0;
        q_wa       = tail_reg;
        q_wd       = off_c;

        if (cmd.sweep)
        begin
            taken_we = 1'b1;
            q_we     = 1'b1;
            q_wa     = idx_reg;
            q_wd     = idx_reg + HOST_BITS'(2);
            idx_next = idx_reg + HOST_BITS'(1);
        end

        if (cmd.exec)
        begin
            case (req_reg.func)
                FUNC_ALLOC:
                begin
                    if (count_reg == '0)
                    begin
                        status_c = STAT_EMPTY;
                    end
                    else
                    begin
                        taken_we   = 1'b1;
                        taken_wa   = q_rdata_reg;
                        taken_wd   = 1'b1;
                        head_next  = head_reg + HOST_BITS'(1);
                        count_next = count_reg - CNT_W'(1);
                        granted_c  = base_reg | 32'(q_rdata_reg);
                    end
                end
                FUNC_RELEASE:
                begin
                    if (hit_c && taken_rdata_reg && !count_reg[HOST_BITS])
                    begin
                        taken_we   = 1'b1;
                        taken_wa   = off_c;
                        taken_wd   = 1'b0;
                        q_we       = 1'b1;
                        tail_next  = tail_reg + HOST_BITS'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_c = STAT_IGNORED;
                    end
                end
                FUNC_REBUILD:
                begin
                    mask_next  = new_mask;
                    base_next  = net_base_reg & new_mask;
                    head_next  = '0;
                    tail_next  = rb_count[HOST_BITS-1:0];
                    count_next = rb_count;
                    idx_next   = '0;
                    last_next  = ~new_mask[HOST_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end

        in_subnet_c = (req_reg.addr_in & mask_next) == base_next;
    end

    assign cnt_ext = {8'd0, count_next};

    // Hold pool control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            mask_reg  <= '1;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            last_reg  <= '1;
            done_reg  <= 1'b0;
        end
        else
        begin
            base_reg  <= base_next;
            mask_reg  <= mask_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            done_reg  <= cmd.emit;
        end
    end

    // Latch request and read both stores
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg         <= req;
            q_rdata_reg     <= free_queue_mem[head_reg];
            taken_rdata_reg <= taken_mem[load_off];
        end
    end

    // Write free queue
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            free_queue_mem[q_wa] <= q_wd;
        end
    end

    // Write allocation bitmap
    always_ff @(posedge clk)
    begin
        if (taken_we)
        begin
            taken_mem[taken_wa] <= taken_wd;
        end
    end

    // Register the result
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            resp_reg.status     <= status_c;
            resp_reg.addr_out   <= granted_c;
            resp_reg.in_subnet  <= in_subnet_c;
            resp_reg.free_count <= cnt_ext[7:0];
        end
    end

    assign stat.is_rebuild = (req_reg.func == FUNC_REBUILD);
    assign stat.sweep_last = (idx_reg == last_reg);
    assign resp            = resp_reg;
    assign done            = done_reg;

endmodule

@@ sv/ip_address_pool_allocator.sv @@
// Allocate, release and rebuild requests: each result is registered and strobes on done.
// A rebuild sweeps 2^(32 - prefix) entries, writing one queue entry a cycle.
// A request is taken only while busy is low; the queue and bitmap are read on accept
// and then updated. The receiver cannot stall; each result is valid only with done.
// After reset (rst_n, async, active low) busy stays high while the bitmap is cleared;
// configuration writes are taken at any time.
module ip_address_pool_allocator
    import ipa_pkg::*;
#(
    parameter int unsigned HOST_BITS = IPA_HOST_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ipa_req_t    req,
    output logic        done,
    output ipa_resp_t   resp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ipa_cmd_t  cmd;
    ipa_stat_t stat;

    // Configuration writes never wait
    assign cfg_ready = 1'b1;

    ipa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ipa_datapath #(
        .HOST_BITS (HOST_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .resp      (resp),
        .done      (done)
    );

endmodule

@@ test/ip_address_pool_allocator_tb.sv @@
// Self-checking testbench for the IPv4 address pool allocator: directed table, then random pools.
module ip_address_pool_allocator_tb;
    import ipa_pkg::*;

    localparam int ITEM_TARGET = 700;
    localparam int STALL_LIMIT = 3000;
    localparam int POOL_DEPTH  = 1 << IPA_HOST_BITS;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [31:0] data;
        logic [1:0]  func;
        logic [31:0] addr;
        bit          typed;
        ipa_resp_t   resp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    ipa_req_t    req;
    logic        done;
    ipa_resp_t   resp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // Shadow copy of the pool
    logic [31:0] net_base_m;
    logic [5:0]  prefix_m;
    logic [7:0]  offset_fifo [POOL_DEPTH];
    logic [7:0]  fifo_head;
    logic [7:0]  fifo_tail;
    int          free_total;
    logic [POOL_DEPTH-1:0] taken_bits;
    logic [31:0] subnet_base_m;
    logic [31:0] subnet_mask_m;

    ipa_resp_t   owed_resp_q [$];
    logic [31:0] granted_addrs [$];
    stim_row_t   stim_rows [$];

    int  err_cnt = 0;
    int  n_items;
    int  n_results = 0;
    int  n_cfg;
    int  n_grants = 0;
    int  n_empty = 0;
    int  n_ignored = 0;
    int  n_settings;
    int  stall_cycles = 0;
    bit  no_gaps;

    ip_address_pool_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .resp      (resp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue one offset at the tail of the free list
    function automatic void push_free(logic [7:0] off);
        offset_fifo[fifo_tail] = off;
        fifo_tail = fifo_tail + 8'd1;
        free_total++;
    endfunction

    // Apply one request to the shadow pool and return the response it earns
    function automatic ipa_resp_t pool_step(ipa_req_t r);
        ipa_resp_t   o;
        int          pfx;
        int          span;
        logic [7:0]  off;
        o = '0;
        o.status = STAT_DONE;
        case (r.func)
            FUNC_ALLOC:
            begin
                if (free_total == 0)
                    o.status = STAT_EMPTY;
                else
                begin
                    off = offset_fifo[fifo_head];
                    fifo_head = fifo_head + 8'd1;
                    free_total--;
                    taken_bits[off] = 1'b1;
                    o.addr_out = subnet_base_m | {24'd0, off};
                end
            end
            FUNC_RELEASE:
            begin
                off = r.addr_in[7:0] & ~subnet_mask_m[7:0];
                if ((r.addr_in & subnet_mask_m) == subnet_base_m && taken_bits[off]
                    && free_total < POOL_DEPTH)
                begin
                    taken_bits[off] = 1'b0;
                    push_free(off);
                end
                else
                    o.status = STAT_IGNORED;
            end
            FUNC_REBUILD:
            begin
                pfx = prefix_m;
                if (pfx > 32)
                    pfx = 32;
                if (pfx < 32 - IPA_HOST_BITS)
                    pfx = 32 - IPA_HOST_BITS;
                span = 1 << (32 - pfx);
                subnet_mask_m = ~(span - 1);
                subnet_base_m = net_base_m & subnet_mask_m;
                taken_bits = '0;
                fifo_head = '0;
                fifo_tail = '0;
                free_total = 0;
                if (span > 3)
                    for (int i = 2; i < span - 1; i++)
                        push_free(i[7:0]);
            end
            default: ;
        endcase
        o.in_subnet = ((r.addr_in & subnet_mask_m) == subnet_base_m);
        o.free_count = free_total[7:0];
        return o;
    endfunction

    // Present one request after a random gap and log what it should return
    task automatic issue_request(input logic [1:0] f, input logic [31:0] a,
                                 input bit typed, input ipa_resp_t typed_resp);
        int        gap;
        ipa_req_t  r;
        ipa_resp_t pred;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        r.func = f;
        r.addr_in = a;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        pred = pool_step(r);
        if (f == FUNC_ALLOC && pred.status == STAT_DONE)
            granted_addrs.push_back(pred.addr_out);
        if (f == FUNC_REBUILD)
            granted_addrs.delete();
        owed_resp_q.push_back(typed ? typed_resp : pred);
        n_items++;
    endtask

    // Hold off new requests until every response is back
    task automatic settle_pool();
        @(negedge clk);
        start <= 1'b0;
        while (owed_resp_q.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_NET_BASE)
            net_base_m = val;
        else if (idx == REG_PREFIX_LEN)
            prefix_m = val[5:0];
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_req(logic [1:0] f, logic [31:0] a, bit typed,
                                    logic [1:0] st, logic [31:0] ao, logic ins, logic [7:0] fc);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.idx = '0;
        row.data = '0;
        row.func = f;
        row.addr = a;
        row.typed = typed;
        row.resp.status = st;
        row.resp.addr_out = ao;
        row.resp.in_subnet = ins;
        row.resp.free_count = fc;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [7:0] idx, logic [31:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, idx: idx, data: val, func: FUNC_NOP, addr: '0,
                typed: 1'b0, resp: '0};
        stim_rows.push_back(row);
    endfunction

    // Address inside the current subnet with a random host part
    function automatic logic [31:0] host_addr();
        return subnet_base_m | ($urandom() & ~subnet_mask_m);
    endfunction

    // Compare each strobed response with the oldest owed one
    always @(posedge clk)
    begin : check_results
        ipa_resp_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (resp.status == STAT_DONE && resp.addr_out != '0)
                n_grants++;
            if (resp.status == STAT_EMPTY)
                n_empty++;
            if (resp.status == STAT_IGNORED)
                n_ignored++;
            if (owed_resp_q.size() == 0)
            begin
                $error("response with none owed: status %0d addr_out %h", resp.status,
                       resp.addr_out);
                err_cnt++;
            end
            else
            begin
                want = owed_resp_q.pop_front();
                if (resp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, resp.status);
                    err_cnt++;
                end
                if (resp.addr_out !== want.addr_out)
                begin
                    $error("addr_out: expected %h, got %h", want.addr_out, resp.addr_out);
                    err_cnt++;
                end
                if (resp.in_subnet !== want.in_subnet)
                begin
                    $error("in_subnet: expected %0d, got %0d", want.in_subnet,
                           resp.in_subnet);
                    err_cnt++;
                end
                if (resp.free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, got %0d", want.free_count,
                           resp.free_count);
                    err_cnt++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int          alloc_pct;
        int          span_len;
        int          pick;
        int          sel;
        logic [31:0] val;
        logic [31:0] a;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_items = 0;
        n_cfg = 0;
        n_settings = 0;
        no_gaps = 1'b0;
        net_base_m = '0;
        prefix_m = PREFIX_RESET;
        fifo_head = '0;
        fifo_tail = '0;
        free_total = 0;
        taken_bits = '0;
        subnet_base_m = '0;
        subnet_mask_m = '1;
        for (int i = 0; i < POOL_DEPTH; i++)
            offset_fifo[i] = '0;

        // Directed table: empty pool after reset, then edge-case subnets
        add_req(FUNC_ALLOC,   32'h0000_0000, 1, STAT_EMPTY,   '0, 1'b1, 8'd0);
        add_req(FUNC_RELEASE, 32'h0000_0000, 1, STAT_IGNORED, '0, 1'b1, 8'd0);
        add_req(FUNC_RELEASE, 32'hFFFF_FFFF, 1, STAT_IGNORED, '0, 1'b0, 8'd0);
        add_req(FUNC_NOP,     32'h1234_5678, 1, STAT_DONE,    '0, 1'b0, 8'd0);
        add_cfg(REG_NET_BASE, 32'hC0A8_01FF);
        add_cfg(REG_PREFIX_LEN, 32'd24);
        add_req(FUNC_REBUILD, 32'hC0A8_0155, 1, STAT_DONE, '0, 1'b1, 8'd253);
        add_req(FUNC_ALLOC,   32'h0000_0000, 1, STAT_DONE, 32'hC0A8_0102, 1'b0, 8'd252);
        add_req(FUNC_ALLOC,   32'hFFFF_FFFF, 1, STAT_DONE, 32'hC0A8_0103, 1'b0, 8'd251);
        add_req(FUNC_RELEASE, 32'hC0A8_0102, 1, STAT_DONE,    '0, 1'b1, 8'd252);
        add_req(FUNC_RELEASE, 32'hC0A8_0102, 1, STAT_IGNORED, '0, 1'b1, 8'd252);
        add_req(FUNC_RELEASE, 32'hC0A9_0103, 1, STAT_IGNORED, '0, 1'b0, 8'd252);
        add_req(FUNC_RELEASE, 32'hC0A8_0100, 0, '0, '0, 1'b0, '0);
        add_req(FUNC_NOP,     32'hC0A8_0104, 0, '0, '0, 1'b0, '0);
        add_cfg(REG_PREFIX_LEN, 32'd32);
        add_req(FUNC_REBUILD, 32'hC0A8_01FF, 1, STAT_DONE,  '0, 1'b1, 8'd0);
        add_req(FUNC_ALLOC,   32'hC0A8_01FE, 1, STAT_EMPTY, '0, 1'b0, 8'd0);
        add_cfg(REG_PREFIX_LEN, 32'd31);
        add_req(FUNC_REBUILD, 32'hC0A8_01FE, 0, '0, '0, 1'b0, '0);
        add_cfg(REG_PREFIX_LEN, 32'd30);
        add_req(FUNC_REBUILD, 32'hC0A8_01FC, 0, '0, '0, 1'b0, '0);
        add_req(FUNC_ALLOC,   32'hC0A8_01FD, 0, '0, '0, 1'b0, '0);
        add_req(FUNC_ALLOC,   32'h0000_0000, 1, STAT_EMPTY, '0, 1'b0, 8'd0);
        // Prefix below range saturates to the widest pool
        add_cfg(REG_PREFIX_LEN, 32'd0);
        add_cfg(REG_NET_BASE, 32'hFFFF_FFFF);
        add_req(FUNC_REBUILD, 32'h0000_0000, 1, STAT_DONE, '0, 1'b0, 8'd253);
        add_req(FUNC_ALLOC,   32'hFFFF_FF00, 1, STAT_DONE, 32'hFFFF_FF02, 1'b1, 8'd252);
        // Prefix above range saturates to 32; unknown indexes change nothing
        add_cfg(REG_PREFIX_LEN, 32'd63);
        add_cfg(8'd2, 32'h0000_003F);
        add_cfg(8'hFF, 32'hFFFF_FFFF);
        add_req(FUNC_REBUILD, 32'hFFFF_FFFF, 1, STAT_DONE,    '0, 1'b1, 8'd0);
        add_req(FUNC_RELEASE, 32'hFFFF_FFFF, 1, STAT_IGNORED, '0, 1'b1, 8'd0);
        add_cfg(REG_NET_BASE, 32'h0000_0000);
        add_cfg(REG_PREFIX_LEN, 32'd24);
        add_req(FUNC_REBUILD, 32'h0000_00FF, 0, '0, '0, 1'b0, '0);

        // Release reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                settle_pool();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end
            else
                issue_request(stim_rows[i].func, stim_rows[i].addr, stim_rows[i].typed,
                              stim_rows[i].resp);
        end

        // Random pools: reconfigure, rebuild, then mostly well-formed traffic
        while (n_items < ITEM_TARGET)
        begin
            settle_pool();
            n_settings++;
            write_reg(REG_NET_BASE, $urandom());
            val = $urandom();
            sel = $urandom_range(0, 9);
            if (n_settings == 1)
                val[5:0] = 6'd24;
            else if (sel == 0)
                val[5:0] = 6'($urandom_range(0, 23));
            else if (sel == 1)
                val[5:0] = 6'($urandom_range(33, 63));
            else
                val[5:0] = 6'($urandom_range(24, 32));
            write_reg(REG_PREFIX_LEN, val);
            if ($urandom_range(0, 7) == 0)
                write_reg(8'($urandom_range(2, 255)), $urandom());
            issue_request(FUNC_REBUILD, $urandom(), 0, '0);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (n_settings == 1)
            begin
                span_len = 300;
                alloc_pct = 90;
            end
            else
            begin
                span_len = $urandom_range(30, 120);
                alloc_pct = $urandom_range(25, 85);
            end
            for (int k = 0; k < span_len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct)
                begin
                    a = $urandom_range(0, 1) ? host_addr() : $urandom();
                    issue_request(FUNC_ALLOC, a, 0, '0);
                end
                else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4
                         && granted_addrs.size() != 0)
                begin
                    // Return a granted address; sometimes keep it for a double release
                    sel = $urandom_range(0, granted_addrs.size() - 1);
                    a = granted_addrs[sel];
                    if ($urandom_range(0, 4) != 0)
                        granted_addrs.delete(sel);
                    issue_request(FUNC_RELEASE, a, 0, '0);
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: issue_request(FUNC_RELEASE, host_addr(), 0, '0);
                        3, 4:    issue_request(FUNC_RELEASE, $urandom(), 0, '0);
                        5:       issue_request(FUNC_NOP, $urandom(), 0, '0);
                        6:       issue_request(FUNC_REBUILD, $urandom(), 0, '0);
                        default: issue_request(FUNC_ALLOC, $urandom(), 0, '0);
                    endcase
                end
            end
        end

        // Drain and let the block go quiet
        @(negedge clk);
        start <= 1'b0;
        while (owed_resp_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d requests and %0d responses over %0d random pool settings,",
                 n_items, n_results, n_settings);
        $display("with %0d grants, %0d empty-pool allocates, %0d ignored releases, %0d reg writes.",
                 n_grants, n_empty, n_ignored, n_cfg);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
